@@ rtl/jqs_pkg.sv @@
// types, constants and tables shared by the quality scaler
`timescale 1ns / 1ps

package jqs_pkg;

  localparam int unsigned QualWidth  = 7;
  localparam int unsigned EntryWidth = 8;
  localparam int unsigned NumWidth   = 14;
  localparam int unsigned RecipWidth = 21;
  localparam int unsigned RecipShift = 21;
  localparam int unsigned ProdWidth  = NumWidth + RecipWidth;
  localparam int unsigned QuotWidth  = ProdWidth - RecipShift;

  localparam logic [QualWidth-1:0] QualMin   = 7'd1;
  localparam logic [QualWidth-1:0] QualMax   = 7'd100;
  localparam logic [QualWidth-1:0] QualReset = 7'd50;
  localparam logic [QualWidth-1:0] QualKnee  = 7'd50;

  localparam logic [EntryWidth-1:0] OutMin = 8'd1;
  localparam logic [EntryWidth-1:0] OutMax = 8'd255;

  localparam int unsigned RecipNum = 2 ** 20;
  localparam logic [RecipWidth-1:0] HiRecip = 21'((2 ** 21 + 100 - 1) / 100);
  localparam logic [QualWidth-1:0]  HiBias  = 7'd50;
  localparam logic [QualWidth-1:0]  LoMult  = 7'd100;

  // config-derived coefficients of the scaling datapath
  typedef struct packed {
    logic [QualWidth-1:0]  mult;
    logic [QualWidth-1:0]  bias;
    logic [RecipWidth-1:0] recip;
  } coef_t;

  localparam logic [EntryWidth-1:0] BaseRom [0:127] = '{
    8'd16, 8'd11, 8'd10, 8'd16, 8'd24, 8'd40, 8'd51, 8'd61,
    8'd12, 8'd12, 8'd14, 8'd19, 8'd26, 8'd58, 8'd60, 8'd55,
    8'd14, 8'd13, 8'd16, 8'd24, 8'd40, 8'd57, 8'd69, 8'd56,
    8'd14, 8'd17, 8'd22, 8'd29, 8'd51, 8'd87, 8'd80, 8'd62,
    8'd18, 8'd22, 8'd37, 8'd56, 8'd68, 8'd109, 8'd103, 8'd77,
    8'd24, 8'd35, 8'd55, 8'd64, 8'd81, 8'd104, 8'd113, 8'd92,
    8'd49, 8'd64, 8'd78, 8'd87, 8'd103, 8'd121, 8'd120, 8'd101,
    8'd72, 8'd92, 8'd95, 8'd98, 8'd112, 8'd100, 8'd103, 8'd99,
    8'd17, 8'd18, 8'd24, 8'd47, 8'd99, 8'd99, 8'd99, 8'd99,
    8'd18, 8'd21, 8'd26, 8'd66, 8'd99, 8'd99, 8'd99, 8'd99,
    8'd24, 8'd26, 8'd56, 8'd99, 8'd99, 8'd99, 8'd99, 8'd99,
    8'd47, 8'd66, 8'd99, 8'd99, 8'd99, 8'd99, 8'd99, 8'd99,
    8'd99, 8'd99, 8'd99, 8'd99, 8'd99, 8'd99, 8'd99, 8'd99,
    8'd99, 8'd99, 8'd99, 8'd99, 8'd99, 8'd99, 8'd99, 8'd99,
    8'd99, 8'd99, 8'd99, 8'd99, 8'd99, 8'd99, 8'd99, 8'd99,
    8'd99, 8'd99, 8'd99, 8'd99, 8'd99, 8'd99, 8'd99, 8'd99
  };

  // ceil(2^21 / (2q)) for the low-quality branch, exact for 14-bit numerators
  function automatic logic [RecipWidth-1:0] lo_recip(input logic [QualWidth-1:0] q);
    logic [RecipWidth-1:0] r;
    begin
      case (q)
        7'd1:  r = 21'((RecipNum + 1 - 1) / 1);
        7'd2:  r = 21'((RecipNum + 2 - 1) / 2);
        7'd3:  r = 21'((RecipNum + 3 - 1) / 3);
        7'd4:  r = 21'((RecipNum + 4 - 1) / 4);
        7'd5:  r = 21'((RecipNum + 5 - 1) / 5);
        7'd6:  r = 21'((RecipNum + 6 - 1) / 6);
        7'd7:  r = 21'((RecipNum + 7 - 1) / 7);
        7'd8:  r = 21'((RecipNum + 8 - 1) / 8);
        7'd9:  r = 21'((RecipNum + 9 - 1) / 9);
        7'd10: r = 21'((RecipNum + 10 - 1) / 10);
        7'd11: r = 21'((RecipNum + 11 - 1) / 11);
        7'd12: r = 21'((RecipNum + 12 - 1) / 12);
        7'd13: r = 21'((RecipNum + 13 - 1) / 13);
        7'd14: r = 21'((RecipNum + 14 - 1) / 14);
        7'd15: r = 21'((RecipNum + 15 - 1) / 15);
        7'd16: r = 21'((RecipNum + 16 - 1) / 16);
        7'd17: r = 21'((RecipNum + 17 - 1) / 17);
        7'd18: r = 21'((RecipNum + 18 - 1) / 18);
        7'd19: r = 21'((RecipNum + 19 - 1) / 19);
        7'd20: r = 21'((RecipNum + 20 - 1) / 20);
        7'd21: r = 21'((RecipNum + 21 - 1) / 21);
        7'd22: r = 21'((RecipNum + 22 - 1) / 22);
        7'd23: r = 21'((RecipNum + 23 - 1) / 23);
        7'd24: r = 21'((RecipNum + 24 - 1) / 24);
        7'd25: r = 21'((RecipNum + 25 - 1) / 25);
        7'd26: r = 21'((RecipNum + 26 - 1) / 26);
        7'd27: r = 21'((RecipNum + 27 - 1) / 27);
        7'd28: r = 21'((RecipNum + 28 - 1) / 28);
        7'd29: r = 21'((RecipNum + 29 - 1) / 29);
        7'd30: r = 21'((RecipNum + 30 - 1) / 30);
        7'd31: r = 21'((RecipNum + 31 - 1) / 31);
        7'd32: r = 21'((RecipNum + 32 - 1) / 32);
        7'd33: r = 21'((RecipNum + 33 - 1) / 33);
        7'd34: r = 21'((RecipNum + 34 - 1) / 34);
        7'd35: r = 21'((RecipNum + 35 - 1) / 35);
        7'd36: r = 21'((RecipNum + 36 - 1) / 36);
        7'd37: r = 21'((RecipNum + 37 - 1) / 37);
        7'd38: r = 21'((RecipNum + 38 - 1) / 38);
        7'd39: r = 21'((RecipNum + 39 - 1) / 39);
        7'd40: r = 21'((RecipNum + 40 - 1) / 40);
        7'd41: r = 21'((RecipNum + 41 - 1) / 41);
        7'd42: r = 21'((RecipNum + 42 - 1) / 42);
        7'd43: r = 21'((RecipNum + 43 - 1) / 43);
        7'd44: r = 21'((RecipNum + 44 - 1) / 44);
        7'd45: r = 21'((RecipNum + 45 - 1) / 45);
        7'd46: r = 21'((RecipNum + 46 - 1) / 46);
        7'd47: r = 21'((RecipNum + 47 - 1) / 47);
        7'd48: r = 21'((RecipNum + 48 - 1) / 48);
        7'd49: r = 21'((RecipNum + 49 - 1) / 49);
        default: r = HiRecip;
      endcase
      return r;
    end
  endfunction

endpackage

@@ rtl/jpeg_quant_table_quality_scaler_top.sv @@
// jpeg quality scaler: quantisation table lookup, scaling and clamping pipeline
// usage:
//   a request (table_select_i, entry_index_i) is taken when start_i is high
//   and busy_o is low; busy_o is always low, so one request per cycle
//   the result appears on scaled_value_o, echo_index_o and echo_table_o for
//   exactly one cycle, flagged by result_valid_o, after passing in order through
//   the four register stages (rom, numerator multiply, reciprocal multiply,
//   clamp) that follow the accepting edge; throughput is one transaction per
//   cycle
//   quality is written with quality_we_i/quality_i while no transaction is in
//   flight; it is clamped to 1..100 and turned into scaling coefficients
//   (multiplier, bias, reciprocal) at the write
//   division by 2q or by 100 is an exact multiply by a 21-bit reciprocal
//   reset clears all valid flags and sets quality 50
//   the receiver cannot stall, so results are never held back
`timescale 1ns / 1ps

module jpeg_quant_table_quality_scaler_top (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start_i,
  output logic       busy_o,
  input  logic       table_select_i,
  input  logic [5:0] entry_index_i,
  input  logic       quality_we_i,
  input  logic [6:0] quality_i,
  output logic       result_valid_o,
  output logic [7:0] scaled_value_o,
  output logic [5:0] echo_index_o,
  output logic [0:0] echo_table_o
);

  logic [jqs_pkg::QualWidth-1:0] qual_clamp;
  jqs_pkg::coef_t                coef_d, coef_q;

  logic                           v1_q, v2_q, v3_q, v4_q;
  logic [5:0]                     idx1_q, idx2_q, idx3_q, idx4_q;
  logic                           sel1_q, sel2_q, sel3_q, sel4_q;
  logic [jqs_pkg::EntryWidth-1:0] t1_q;
  logic [jqs_pkg::NumWidth-1:0]   num_d, num2_q;
  logic [jqs_pkg::ProdWidth-1:0]  prod;
  logic [jqs_pkg::QuotWidth-1:0]  quot_d, quot3_q;
  logic [jqs_pkg::EntryWidth-1:0] val_d, val4_q;
  logic                           accept;

  assign busy_o = 1'b0;
  assign accept = start_i & ~busy_o;

  // quality to coefficients
  always_comb begin
    if (quality_i < jqs_pkg::QualMin) begin
      qual_clamp = jqs_pkg::QualMin;
    end else if (quality_i > jqs_pkg::QualMax) begin
      qual_clamp = jqs_pkg::QualMax;
    end else begin
      qual_clamp = quality_i;
    end
    if (qual_clamp < jqs_pkg::QualKnee) begin
      coef_d.mult  = jqs_pkg::LoMult;
      coef_d.bias  = qual_clamp;
      coef_d.recip = jqs_pkg::lo_recip(qual_clamp);
    end else begin
      coef_d.mult  = 7'(8'd200 - {qual_clamp, 1'b0});
      coef_d.bias  = jqs_pkg::HiBias;
      coef_d.recip = jqs_pkg::HiRecip;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coef_q.mult  <= 7'(8'd200 - {jqs_pkg::QualReset, 1'b0});
      coef_q.bias  <= jqs_pkg::HiBias;
      coef_q.recip <= jqs_pkg::HiRecip;
    end else if (quality_we_i) begin
      coef_q <= coef_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      v1_q <= accept;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
    end
  end

  // stage 1: table lookup
  always_ff @(posedge clk_i) begin
    if (accept) begin
      t1_q   <= jqs_pkg::BaseRom[{table_select_i, entry_index_i}];
      idx1_q <= entry_index_i;
      sel1_q <= table_select_i;
    end
  end

  // stage 2: numerator
  assign num_d = jqs_pkg::NumWidth'(t1_q) * jqs_pkg::NumWidth'(coef_q.mult)
               + jqs_pkg::NumWidth'(coef_q.bias);

  always_ff @(posedge clk_i) begin
    if (v1_q) begin
      num2_q <= num_d;
      idx2_q <= idx1_q;
      sel2_q <= sel1_q;
    end
  end

  // stage 3: reciprocal multiply
  assign prod   = jqs_pkg::ProdWidth'(num2_q) * jqs_pkg::ProdWidth'(coef_q.recip);
  assign quot_d = prod[jqs_pkg::ProdWidth-1:jqs_pkg::RecipShift];

  always_ff @(posedge clk_i) begin
    if (v2_q) begin
      quot3_q <= quot_d;
      idx3_q  <= idx2_q;
      sel3_q  <= sel2_q;
    end
  end

  // stage 4: clamp
  always_comb begin
    if (quot3_q < jqs_pkg::QuotWidth'(jqs_pkg::OutMin)) begin
      val_d = jqs_pkg::OutMin;
    end else if (quot3_q > jqs_pkg::QuotWidth'(jqs_pkg::OutMax)) begin
      val_d = jqs_pkg::OutMax;
    end else begin
      val_d = quot3_q[jqs_pkg::EntryWidth-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (v3_q) begin
      val4_q <= val_d;
      idx4_q <= idx3_q;
      sel4_q <= sel3_q;
    end
  end

  assign result_valid_o  = v4_q;
  assign scaled_value_o  = val4_q;
  assign echo_index_o    = idx4_q;
  assign echo_table_o[0] = sel4_q;

endmodule

@@ tb/testbench.sv @@
// self-checking testbench for the jpeg quantisation table quality scaler
`timescale 1ns / 1ps

module testbench;

  localparam int unsigned CycleLimit = 200000;
  localparam int unsigned DrainCycles = 8;
  localparam int unsigned NumPhases = 16;
  localparam int unsigned ItemsPerPhase = 122;

  localparam logic [7:0] LUMA_BASE [64] = '{
    8'd16, 8'd11, 8'd10, 8'd16, 8'd24, 8'd40, 8'd51, 8'd61,
    8'd12, 8'd12, 8'd14, 8'd19, 8'd26, 8'd58, 8'd60, 8'd55,
    8'd14, 8'd13, 8'd16, 8'd24, 8'd40, 8'd57, 8'd69, 8'd56,
    8'd14, 8'd17, 8'd22, 8'd29, 8'd51, 8'd87, 8'd80, 8'd62,
    8'd18, 8'd22, 8'd37, 8'd56, 8'd68, 8'd109, 8'd103, 8'd77,
    8'd24, 8'd35, 8'd55, 8'd64, 8'd81, 8'd104, 8'd113, 8'd92,
    8'd49, 8'd64, 8'd78, 8'd87, 8'd103, 8'd121, 8'd120, 8'd101,
    8'd72, 8'd92, 8'd95, 8'd98, 8'd112, 8'd100, 8'd103, 8'd99
  };

  // chrominance outside the top-left 4x4 corner is flat 99
  localparam logic [7:0] CHROMA_CORNER [16] = '{
    8'd17, 8'd18, 8'd24, 8'd47,
    8'd18, 8'd21, 8'd26, 8'd66,
    8'd24, 8'd26, 8'd56, 8'd99,
    8'd47, 8'd66, 8'd99, 8'd99
  };
  localparam logic [7:0] CHROMA_FLAT = 8'd99;

  typedef struct packed {
    logic [7:0] value;
    logic [5:0] index;
    logic       tbl;
  } quant_result_t;

  class qscale_scoreboard;
    logic [jqs_pkg::QualWidth-1:0] quality;
    quant_result_t pending_quants[$];
    int unsigned errors;
    int unsigned requests;
    int unsigned checked;

    function new();
      quality = 7'd50;
      errors = 0;
      requests = 0;
      checked = 0;
    endfunction

    function logic [7:0] base_entry(input logic tbl, input logic [5:0] index);
      if (!tbl) return LUMA_BASE[index];
      if (index[5] == 1'b0 && index[2] == 1'b0)
        return CHROMA_CORNER[{index[4:3], index[1:0]}];
      return CHROMA_FLAT;
    endfunction

    function logic [7:0] scaled_quant(input logic [7:0] base);
      int unsigned q;
      int unsigned v;
      q = 32'(quality);
      if (q < 1) q = 1;
      if (q > 100) q = 100;
      if (q < 50) v = (100 * base + q) / (2 * q);
      else v = (base * (200 - 2 * q) + 50) / 100;
      if (v < 1) v = 1;
      if (v > 255) v = 255;
      return v[7:0];
    endfunction

    function void log_request(input logic tbl, input logic [5:0] index);
      quant_result_t exp_res;
      exp_res.value = scaled_quant(base_entry(tbl, index));
      exp_res.index = index;
      exp_res.tbl = tbl;
      pending_quants.push_back(exp_res);
      requests++;
    endfunction

    function void check_result(input logic [7:0] value, input logic [5:0] index,
                               input logic tbl);
      quant_result_t exp_res;
      if (pending_quants.size() == 0) begin
        $error("unexpected result value %0d index %0d table %0d", value, index, tbl);
        errors++;
        return;
      end
      exp_res = pending_quants.pop_front();
      checked++;
      if (value !== exp_res.value) begin
        $error("scaled_value expected %0d actual %0d", exp_res.value, value);
        errors++;
      end
      if (index !== exp_res.index) begin
        $error("echo_index expected %0d actual %0d", exp_res.index, index);
        errors++;
      end
      if (tbl !== exp_res.tbl) begin
        $error("echo_table expected %0d actual %0d", exp_res.tbl, tbl);
        errors++;
      end
    endfunction

    function int unsigned outstanding();
      return pending_quants.size();
    endfunction
  endclass

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       start_i = 1'b0;
  logic       busy_o;
  logic       table_select_i = 1'b0;
  logic [5:0] entry_index_i = '0;
  logic       quality_we_i = 1'b0;
  logic [6:0] quality_i = '0;
  logic       result_valid_o;
  logic [7:0] scaled_value_o;
  logic [5:0] echo_index_o;
  logic [0:0] echo_table_o;

  qscale_scoreboard sb = new();
  int unsigned cycles = 0;
  int unsigned settings = 1;

  jpeg_quant_table_quality_scaler_top dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start_i       (start_i),
    .busy_o        (busy_o),
    .table_select_i(table_select_i),
    .entry_index_i (entry_index_i),
    .quality_we_i  (quality_we_i),
    .quality_i     (quality_i),
    .result_valid_o(result_valid_o),
    .scaled_value_o(scaled_value_o),
    .echo_index_o  (echo_index_o),
    .echo_table_o  (echo_table_o)
  );

  always #10 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && result_valid_o) begin
      sb.check_result(scaled_value_o, echo_index_o, echo_table_o[0]);
    end
  end

  task automatic send_entry(input logic tbl, input logic [5:0] index);
    start_i <= 1'b1;
    table_select_i <= tbl;
    entry_index_i <= index;
    do @(posedge clk_i); while (busy_o);
    sb.log_request(tbl, index);
  endtask

  task automatic pause_sender(input int unsigned gap);
    start_i <= 1'b0;
    repeat (gap) @(posedge clk_i);
  endtask

  task automatic drain_results();
    start_i <= 1'b0;
    while (sb.outstanding() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic write_quality(input logic [6:0] q);
    drain_results();
    quality_we_i <= 1'b1;
    quality_i <= q;
    @(posedge clk_i);
    quality_we_i <= 1'b0;
    sb.quality = q;
    settings++;
  endtask

  task automatic directed_corners();
    send_entry(1'b0, 6'd0);
    send_entry(1'b0, 6'd53);
    send_entry(1'b1, 6'd63);
    send_entry(1'b1, 6'd0);
  endtask

  task automatic random_phase(input int unsigned count);
    int unsigned left;
    int unsigned burst;
    left = count;
    while (left > 0) begin
      burst = $urandom_range(1, 20);
      if (burst > left) burst = left;
      repeat (burst) send_entry(1'($urandom_range(0, 1)), 6'($urandom_range(0, 63)));
      left -= burst;
      if ($urandom_range(0, 3) != 0) pause_sender($urandom_range(1, 6));
    end
  endtask

  initial begin
    logic [6:0] phase_q [8];
    logic [6:0] q;
    phase_q = '{7'd1, 7'd100, 7'd0, 7'd127, 7'd49, 7'd51, 7'd2, 7'd99};
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset quality (50, the knee) first, then below-range, above-range, 100, 49 and 1
    directed_corners();
    write_quality(7'd0);
    directed_corners();
    write_quality(7'd127);
    directed_corners();
    write_quality(7'd100);
    directed_corners();
    write_quality(7'd49);
    directed_corners();
    write_quality(7'd1);
    directed_corners();

    for (int unsigned p = 0; p < NumPhases; p++) begin
      if (p < 8) q = phase_q[p];
      else if ($urandom_range(0, 1) != 0) q = 7'($urandom_range(1, 100));
      else q = 7'($urandom_range(0, 127));
      write_quality(q);
      random_phase(ItemsPerPhase);
    end

    drain_results();
    $display("checked %0d of %0d table lookups over %0d quality settings",
             sb.checked, sb.requests, settings);
    $display("qualities included 0, 1, 49, 50, 51, 100 and 127, both tables, bursty sender");
    if (sb.errors == 0 && sb.outstanding() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

@@ files.f @@
rtl/jqs_pkg.sv
rtl/jpeg_quant_table_quality_scaler_top.sv
tb/testbench.sv
